// ----- rtl/ctsr_pkg.sv -----
`default_nettype none

package ctsr_pkg;

  // geometry of the tag store
  localparam int LINES     = 256;
  localparam int LINE_AW   = $clog2(LINES);
  localparam int LINE_CW   = LINE_AW + 1;
  localparam int ADDR_W    = 32;
  localparam int TAG_W     = 32;
  localparam int STAMP_W   = 32;
  localparam int IB_W      = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAPPING_MODE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_POLICY = 2'd3;

  localparam logic [4:0]      RST_OFFSET_BITS = 5'd4;
  localparam logic [IB_W-1:0] RST_INDEX_BITS  = 4'd8;

  localparam logic MODE_DIRECT = 1'b0;
  localparam logic MODE_ASSOC  = 1'b1;
  localparam logic POL_FIFO    = 1'b0;
  localparam logic POL_LRU     = 1'b1;

  // one line presented to the search unit
  typedef struct packed {
    logic               en;
    logic [LINE_AW-1:0] idx;
    logic               vld;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } ctsr_entry_t;

  // running outcome of an associative search
  typedef struct packed {
    logic               found;
    logic [LINE_AW-1:0] where;
    logic               have_free;
    logic [LINE_AW-1:0] free_idx;
    logic               have_old;
    logic [LINE_AW-1:0] old_idx;
    logic [STAMP_W-1:0] old_stamp;
    logic [TAG_W-1:0]   old_tag;
  } ctsr_srch_t;

endpackage

`default_nettype wire

// ----- rtl/ctsr_if.sv -----
`default_nettype none

// request channel: one byte address
interface ctsr_req_if;
  import ctsr_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

// response channel: lookup outcome
interface ctsr_rsp_if;
  import ctsr_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic             victim_valid;
  logic [TAG_W-1:0] victim_tag;
  modport source (output valid, output hit, output victim_valid, output victim_tag,
                  input ready);
  modport sink (input valid, input hit, input victim_valid, input victim_tag,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/ctsr_search.sv -----
`default_nettype none

module ctsr_search import ctsr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              clr_i,
  input  wire logic [TAG_W-1:0]  block_i,
  input  wire ctsr_entry_t       ent_i,
  output      ctsr_srch_t        res_o
);

  ctsr_srch_t res_d, res_q;

  // fold one line into the running match, free and oldest picks
  always_comb begin
    res_d = res_q;
    if (clr_i) begin
      res_d.found     = 1'b0;
      res_d.have_free = 1'b0;
      res_d.have_old  = 1'b0;
    end else if (ent_i.en) begin
      if (ent_i.vld) begin
        if (!res_q.found && ent_i.tag == block_i) begin
          res_d.found = 1'b1;
          res_d.where = ent_i.idx;
        end
        if (!res_q.have_old || ent_i.stamp < res_q.old_stamp) begin
          res_d.have_old  = 1'b1;
          res_d.old_idx   = ent_i.idx;
          res_d.old_stamp = ent_i.stamp;
          res_d.old_tag   = ent_i.tag;
        end
      end else if (!res_q.have_free) begin
        res_d.have_free = 1'b1;
        res_d.free_idx  = ent_i.idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q.found     <= 1'b0;
      res_q.have_free <= 1'b0;
      res_q.have_old  <= 1'b0;
      res_q.where     <= '0;
      res_q.free_idx  <= '0;
      res_q.old_idx   <= '0;
      res_q.old_stamp <= '0;
      res_q.old_tag   <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ----- rtl/cache_tag_store_with_replacement.sv -----
// Cache tag store with FIFO or LRU replacement.
// Requests carry one 32-bit byte address on the req channel; each request
// yields exactly one response on rsp: hit, victim_valid and victim_tag.
// Settings are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the
// user must write them only while the block is idle, which the block itself
// does not enforce; they take effect on the next request.
// Direct-mapped lookup: the request is taken, the line is read from the
// tag/stamp memory, compared and rewritten, and the response is registered.
// Fully associative lookup: the search unit walks the lines in use, one
// memory read per cycle, then writes one line (none on a hit under FIFO).
// Only one request is in flight; req.ready is high while the sequencer idles.
// The response sits in an output register; a new request may be taken while
// it waits, but the next update holds until rsp accepts the previous one.
// Reset clears all line valid bits, the access clock and the settings
// (offset 4, index 8, direct-mapped, FIFO); no clearing pass is needed.
`default_nettype none

module cache_tag_store_with_replacement import ctsr_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ctsr_req_if.sink                   req,
  ctsr_rsp_if.source                 rsp,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DM_RD  = 3'd1;
  localparam logic [2:0] S_DM_CMP = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_FA_UPD = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [4:0]         offset_q;
  logic [IB_W-1:0]    index_bits_q;
  logic               mode_q, policy_q;
  logic [TAG_W-1:0]   block_q, block_d;
  logic [STAMP_W-1:0] clock_q, clock_d;
  logic [LINES-1:0]   valid_q;
  logic [LINE_CW-1:0] ptr_q, ptr_d;
  logic               feed_q, feed_d;
  logic [LINE_AW-1:0] feed_idx_q, feed_idx_d;
  logic               out_valid_q, out_valid_d;
  logic               hit_q, hit_d, vv_q, vv_d;
  logic [TAG_W-1:0]   vtag_q, vtag_d;

  logic [TAG_W+STAMP_W-1:0] line_mem_q [LINES];
  logic [TAG_W+STAMP_W-1:0] rd_q;
  logic [TAG_W-1:0]         rd_tag;
  logic [STAMP_W-1:0]       rd_stamp;

  logic [IB_W-1:0]    ib;
  logic [LINE_CW-1:0] nlines;
  logic [LINE_AW-1:0] dm_idx, raddr, waddr;
  logic               we;
  logic               accept, fin_ok, srch_clr;
  logic               dm_vld, dm_match;
  ctsr_entry_t        ent;
  ctsr_srch_t         srch;

  // effective index width and lines in use
  assign ib     = (index_bits_q > IB_W'(LINE_AW)) ? IB_W'(LINE_AW) : index_bits_q;
  assign nlines = LINE_CW'(1) << ib;
  assign dm_idx = block_q[LINE_AW-1:0] & LINE_AW'(nlines - LINE_CW'(1));

  assign rd_tag   = rd_q[TAG_W-1:0];
  assign rd_stamp = rd_q[TAG_W+STAMP_W-1:TAG_W];

  assign accept   = req.valid && req.ready;
  assign req.ready = (state_q == S_IDLE);
  assign fin_ok   = !out_valid_q || rsp.ready;
  assign srch_clr = accept;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q     <= RST_OFFSET_BITS;
      index_bits_q <= RST_INDEX_BITS;
      mode_q       <= MODE_DIRECT;
      policy_q     <= POL_FIFO;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFFSET_BITS:    offset_q     <= cfg_wdata_i;
        CFG_INDEX_BITS:     index_bits_q <= cfg_wdata_i[IB_W-1:0];
        CFG_MAPPING_MODE:   mode_q       <= cfg_wdata_i[0];
        CFG_REPLACE_POLICY: policy_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // tag and stamp memory, one read and one write port
  assign raddr = (state_q == S_DM_RD || state_q == S_DM_CMP) ? dm_idx
                                                             : ptr_q[LINE_AW-1:0];
  always_ff @(posedge clk_i) begin
    if (we) begin
      line_mem_q[waddr] <= {clock_q + STAMP_W'(1), block_q};
    end
    rd_q <= line_mem_q[raddr];
  end

  // search unit input: the line read in the previous cycle
  assign ent.en    = feed_q && (state_q == S_SCAN);
  assign ent.idx   = feed_idx_q;
  assign ent.vld   = valid_q[feed_idx_q];
  assign ent.tag   = rd_tag;
  assign ent.stamp = rd_stamp;

  ctsr_search u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (srch_clr),
    .block_i (block_q),
    .ent_i   (ent),
    .res_o   (srch)
  );

  // direct-mapped compare on the stored block address
  assign dm_vld   = valid_q[dm_idx];
  assign dm_match = dm_vld && ((rd_tag >> ib) == (block_q >> ib));

  // sequencer
  always_comb begin
    state_d     = state_q;
    block_d     = block_q;
    clock_d     = clock_q;
    ptr_d       = ptr_q;
    feed_d      = 1'b0;
    feed_idx_d  = feed_idx_q;
    out_valid_d = out_valid_q && !rsp.ready;
    hit_d       = hit_q;
    vv_d        = vv_q;
    vtag_d      = vtag_q;
    we          = 1'b0;
    waddr       = dm_idx;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          block_d = req.address >> offset_q;
          ptr_d   = '0;
          state_d = (mode_q == MODE_ASSOC) ? S_SCAN : S_DM_RD;
        end
      end
      S_DM_RD: begin
        state_d = S_DM_CMP;
      end
      S_DM_CMP: begin
        if (fin_ok) begin
          we          = 1'b1;
          waddr       = dm_idx;
          clock_d     = clock_q + STAMP_W'(1);
          hit_d       = dm_match;
          vv_d        = dm_vld && !dm_match;
          vtag_d      = (dm_vld && !dm_match) ? (rd_tag >> ib) : '0;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_SCAN: begin
        if (ptr_q < nlines) begin
          feed_d     = 1'b1;
          feed_idx_d = ptr_q[LINE_AW-1:0];
          ptr_d      = ptr_q + LINE_CW'(1);
        end else if (!feed_q) begin
          state_d = S_FA_UPD;
        end
      end
      S_FA_UPD: begin
        if (fin_ok) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (srch.found) begin
            hit_d  = 1'b1;
            vv_d   = 1'b0;
            vtag_d = '0;
            we     = (policy_q == POL_LRU);
            waddr  = srch.where;
          end else begin
            hit_d  = 1'b0;
            we     = 1'b1;
            if (srch.have_free) begin
              waddr  = srch.free_idx;
              vv_d   = 1'b0;
              vtag_d = '0;
            end else begin
              waddr  = srch.old_idx;
              vv_d   = 1'b1;
              vtag_d = srch.old_tag;
            end
          end
          if (we) begin
            clock_d = clock_q + STAMP_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and line valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clock_q     <= '0;
      valid_q     <= '0;
      ptr_q       <= '0;
      feed_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clock_q     <= clock_d;
      ptr_q       <= ptr_d;
      feed_q      <= feed_d;
      out_valid_q <= out_valid_d;
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    block_q    <= block_d;
    feed_idx_q <= feed_idx_d;
    hit_q      <= hit_d;
    vv_q       <= vv_d;
    vtag_q     <= vtag_d;
  end

  // response outputs
  assign rsp.valid        = out_valid_q;
  assign rsp.hit          = hit_q;
  assign rsp.victim_valid = vv_q;
  assign rsp.victim_tag   = vtag_q;

endmodule

`default_nettype wire
